### sv/rtdd_pkg.sv
// ----------------------------------------------------------------------------
// rtdd_pkg: shared types and constants for the rotation direction decoder
// Register indexes, reset values, event codes, phase codes and the config
// and result bundles passed between the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdd_pkg;

    // Default widths of the sample and timestamp fields
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    // Register field widths
    localparam int THR_BITS      = 10;
    localparam int MS_CFG_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int EVENT_BITS    = 3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOCKOUT_MS      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS     = 2'd2;

    // Register reset values
    localparam logic [THR_BITS-1:0]    RST_PHASE_THRESHOLD = 10'd10;
    localparam logic [MS_CFG_BITS-1:0] RST_LOCKOUT_MS      = 16'd40;
    localparam logic [MS_CFG_BITS-1:0] RST_DEBOUNCE_MS     = 16'd50;

    // Event codes
    localparam logic [EVENT_BITS-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_VOLUME_UP   = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_VOLUME_DOWN = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_SCROLL_UP   = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_SCROLL_DOWN = 3'd4;

    typedef enum logic [1:0] {
        PHASE_NONE  = 2'd0,
        PHASE_ONE   = 2'd1,
        PHASE_TWO   = 2'd2,
        PHASE_THREE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [THR_BITS-1:0]    phase_threshold;
        logic [MS_CFG_BITS-1:0] lockout_ms;
        logic [MS_CFG_BITS-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic [EVENT_BITS-1:0] event_code;
        logic                  volume_mode;
        logic                  mode_toggled;
    } t_result;

endpackage

`default_nettype wire

### sv/rtdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtdd_cfg_regs: configuration register file
// Holds threshold, lockout and debounce settings; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdd_cfg_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [rtdd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [rtdd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output rtdd_pkg::t_cfg                            o_cfg
);

    rtdd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_threshold <= rtdd_pkg::RST_PHASE_THRESHOLD;
            r_cfg.lockout_ms      <= rtdd_pkg::RST_LOCKOUT_MS;
            r_cfg.debounce_ms     <= rtdd_pkg::RST_DEBOUNCE_MS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rtdd_pkg::CFG_PHASE_THRESHOLD: begin
                    r_cfg.phase_threshold <= i_cfg_data[rtdd_pkg::THR_BITS-1:0];
                end
                rtdd_pkg::CFG_LOCKOUT_MS: begin
                    r_cfg.lockout_ms <= i_cfg_data[rtdd_pkg::MS_CFG_BITS-1:0];
                end
                rtdd_pkg::CFG_DEBOUNCE_MS: begin
                    r_cfg.debounce_ms <= i_cfg_data[rtdd_pkg::MS_CFG_BITS-1:0];
                end
                default: begin
                    // unused index: drop
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/rtdd_phase_enc.sv
// ----------------------------------------------------------------------------
// rtdd_phase_enc: phase threshold compare and priority encode
// Phase one wins over two, two over three; no active phase gives PHASE_NONE.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdd_phase_enc #(
    parameter int SAMPLE_BITS = rtdd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0]          i_phase_one,
    input  wire logic [SAMPLE_BITS-1:0]          i_phase_two,
    input  wire logic [SAMPLE_BITS-1:0]          i_phase_three,
    input  wire logic [rtdd_pkg::THR_BITS-1:0]   i_threshold,
    output rtdd_pkg::t_phase                     o_phase
);

    localparam int CMP_BITS = (SAMPLE_BITS > rtdd_pkg::THR_BITS) ?
                              SAMPLE_BITS : rtdd_pkg::THR_BITS;

    logic [CMP_BITS-1:0] thr_ext;
    logic                act_one;
    logic                act_two;
    logic                act_three;

    assign thr_ext   = CMP_BITS'(i_threshold);
    assign act_one   = CMP_BITS'(i_phase_one)   > thr_ext;
    assign act_two   = CMP_BITS'(i_phase_two)   > thr_ext;
    assign act_three = CMP_BITS'(i_phase_three) > thr_ext;

    always_comb begin
        priority if (act_one) begin
            o_phase = rtdd_pkg::PHASE_ONE;
        end else if (act_two) begin
            o_phase = rtdd_pkg::PHASE_TWO;
        end else if (act_three) begin
            o_phase = rtdd_pkg::PHASE_THREE;
        end else begin
            o_phase = rtdd_pkg::PHASE_NONE;
        end
    end

endmodule

`default_nettype wire

### sv/rtdd_decide.sv
// ----------------------------------------------------------------------------
// rtdd_decide: button debounce, mode toggle and rotation event decision
// Holds the decoder state and forms one result per transfer. The button is
// evaluated first so a rotation event in the same item sees the new mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdd_decide #(
    parameter int TIME_BITS = rtdd_pkg::TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire rtdd_pkg::t_phase       i_phase,
    input  wire logic                   i_button_level,
    input  wire logic [TIME_BITS-1:0]   i_now_ms,
    input  wire rtdd_pkg::t_cfg         i_cfg,
    output rtdd_pkg::t_result           o_result
);

    rtdd_pkg::t_phase     r_prev_phase;
    logic [TIME_BITS-1:0] r_last_event_ms;
    logic                 r_mode_volume;
    logic                 r_prev_button;
    logic [TIME_BITS-1:0] r_last_press_ms;

    rtdd_pkg::t_phase     n_prev_phase;
    logic [TIME_BITS-1:0] n_last_event_ms;
    logic                 n_mode_volume;
    logic                 n_prev_button;
    logic [TIME_BITS-1:0] n_last_press_ms;

    logic [TIME_BITS-1:0] press_gap;
    logic [TIME_BITS-1:0] event_gap;
    logic                 press_ok;
    logic                 step_cw;
    logic                 step_ccw;
    logic                 event_ok;
    logic [rtdd_pkg::EVENT_BITS-1:0] event_code;

    // wrap-around differences
    assign press_gap = i_now_ms - r_last_press_ms;
    assign event_gap = i_now_ms - r_last_event_ms;

    assign press_ok = !i_button_level && r_prev_button &&
                      (press_gap > TIME_BITS'(i_cfg.debounce_ms));

    assign step_cw  = (r_prev_phase == rtdd_pkg::PHASE_ONE &&
                       i_phase == rtdd_pkg::PHASE_TWO) ||
                      (r_prev_phase == rtdd_pkg::PHASE_TWO &&
                       i_phase == rtdd_pkg::PHASE_THREE) ||
                      (r_prev_phase == rtdd_pkg::PHASE_THREE &&
                       i_phase == rtdd_pkg::PHASE_ONE);
    assign step_ccw = (r_prev_phase == rtdd_pkg::PHASE_ONE &&
                       i_phase == rtdd_pkg::PHASE_THREE) ||
                      (r_prev_phase == rtdd_pkg::PHASE_THREE &&
                       i_phase == rtdd_pkg::PHASE_TWO) ||
                      (r_prev_phase == rtdd_pkg::PHASE_TWO &&
                       i_phase == rtdd_pkg::PHASE_ONE);

    assign event_ok = (step_cw || step_ccw) &&
                      (event_gap >= TIME_BITS'(i_cfg.lockout_ms));

    assign n_mode_volume   = press_ok ? !r_mode_volume : r_mode_volume;
    assign n_last_press_ms = press_ok ? i_now_ms : r_last_press_ms;
    assign n_prev_button   = i_button_level;
    assign n_prev_phase    = i_phase;
    assign n_last_event_ms = event_ok ? i_now_ms : r_last_event_ms;

    always_comb begin
        if (!event_ok) begin
            event_code = rtdd_pkg::EV_NONE;
        end else if (n_mode_volume) begin
            event_code = step_cw ? rtdd_pkg::EV_VOLUME_UP : rtdd_pkg::EV_VOLUME_DOWN;
        end else begin
            event_code = step_cw ? rtdd_pkg::EV_SCROLL_UP : rtdd_pkg::EV_SCROLL_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase    <= rtdd_pkg::PHASE_NONE;
            r_last_event_ms <= '0;
            r_mode_volume   <= 1'b1;
            r_prev_button   <= 1'b1;
            r_last_press_ms <= '0;
        end else if (i_fire) begin
            r_prev_phase    <= n_prev_phase;
            r_last_event_ms <= n_last_event_ms;
            r_mode_volume   <= n_mode_volume;
            r_prev_button   <= n_prev_button;
            r_last_press_ms <= n_last_press_ms;
        end
    end

    assign o_result.event_code   = event_code;
    assign o_result.volume_mode  = n_mode_volume;
    assign o_result.mode_toggled = press_ok;

endmodule

`default_nettype wire

### sv/three_phase_rotation_direction_decoder_unit.sv
// ----------------------------------------------------------------------------
// three_phase_rotation_direction_decoder_unit: rotation direction decoder
// Turns motor-phase ADC samples and a mode button into volume/scroll events.
//
// Input channel: i_in_valid / o_in_stall with three phase samples, the
// button level and a millisecond timestamp. Output channel: o_out_valid /
// i_out_stall with event code, current mode and a mode-toggle flag. Exactly
// one result leaves for every input transfer, in order.
// Configuration: i_cfg_wr_en writes i_cfg_data to the register at
// i_cfg_index (0 threshold, 1 lockout, 2 debounce).
// Path: an input transfer is captured in the input register; the decided
// result is then captured in the result register and shown on the output.
// Throughput: one item per cycle unless the output stalls, set by the single
// pass from input register via compare and decide logic to result register.
// Reset: synchronous, active low; both stages empty, settings return to
// their defaults, mode is volume, button treated as released.
// Stall: a stalled result holds; the input register still drains into the
// result register whenever that register is empty or being taken, so
// o_in_stall rises only when both stages are full and the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module three_phase_rotation_direction_decoder_unit #(
    parameter int SAMPLE_BITS = rtdd_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = rtdd_pkg::TIME_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [rtdd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [rtdd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]              i_phase_one_sample,
    input  wire logic [SAMPLE_BITS-1:0]              i_phase_two_sample,
    input  wire logic [SAMPLE_BITS-1:0]              i_phase_three_sample,
    input  wire logic                                i_button_level,
    input  wire logic [TIME_BITS-1:0]                i_now_ms,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [rtdd_pkg::EVENT_BITS-1:0]          o_event_code,
    output logic                                     o_volume_mode,
    output logic                                     o_mode_toggled
);

    rtdd_pkg::t_cfg    cfg;
    rtdd_pkg::t_phase  phase;
    rtdd_pkg::t_result result;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_phase_one;
    logic [SAMPLE_BITS-1:0] r_phase_two;
    logic [SAMPLE_BITS-1:0] r_phase_three;
    logic                   r_button;
    logic [TIME_BITS-1:0]   r_now_ms;

    logic                   r_out_valid;
    rtdd_pkg::t_result      r_out;

    logic out_free;
    logic in_load;
    logic fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    rtdd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rtdd_phase_enc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_phase (
        .i_phase_one   (r_phase_one),
        .i_phase_two   (r_phase_two),
        .i_phase_three (r_phase_three),
        .i_threshold   (cfg.phase_threshold),
        .o_phase       (phase)
    );

    rtdd_decide #(
        .TIME_BITS (TIME_BITS)
    ) u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_phase        (phase),
        .i_button_level (r_button),
        .i_now_ms       (r_now_ms),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    // input register: refill on every transfer, drop when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_phase_one   <= i_phase_one_sample;
            r_phase_two   <= i_phase_two_sample;
            r_phase_three <= i_phase_three_sample;
            r_button      <= i_button_level;
            r_now_ms      <= i_now_ms;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_code   = r_out.event_code;
    assign o_volume_mode  = r_out.volume_mode;
    assign o_mode_toggled = r_out.mode_toggled;

endmodule

`default_nettype wire
